// ===== sv/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg: shared constants for the quaternion to rotation matrix block
// Output format and divider geometry used by the pipeline modules.
// ----------------------------------------------------------------------------
package qrm_pkg;

  // Matrix entries are signed Q2.16.
  localparam int unsigned OutW   = 18;
  localparam int unsigned FracW  = 16;
  // Quotient bits: one integer bit, the fraction bits and one rounding bit.
  localparam int unsigned QuoW   = FracW + 2;
  // Nine matrix entries.
  localparam int unsigned Lanes  = 9;
  // Tag carried through the divider: {zero quaternion, negative entry}.
  localparam int unsigned TagW   = 2;
  localparam int unsigned TagNeg = 0;
  localparam int unsigned TagZero = 1;
  // Register stages of the front end.
  localparam int unsigned FrontStages = 3;

endpackage

// ===== sv/qrm_front.sv =====
// ----------------------------------------------------------------------------
// qrm_front: products, numerators and norm
// Three stages: ten products, signed numerator sums, magnitude and sign.
// ----------------------------------------------------------------------------
module qrm_front #(
  parameter int CompBits = 16
) (
  input  logic                  clk_i,
  input  logic [2:0]            en_i,
  input  logic [CompBits-1:0]   x_i,
  input  logic [CompBits-1:0]   y_i,
  input  logic [CompBits-1:0]   z_i,
  input  logic [CompBits-1:0]   w_i,
  output logic [2*CompBits+1:0] den_o,
  output logic [2*CompBits+1:0] mag_o [qrm_pkg::Lanes],
  output logic [qrm_pkg::Lanes-1:0] neg_o,
  output logic                  zero_o
);

  localparam int PW = 2 * CompBits;
  localparam int W  = 2 * CompBits + 2;

  logic signed [PW-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [W-1:0]  num_d [qrm_pkg::Lanes];
  logic signed [W-1:0]  num_q [qrm_pkg::Lanes];
  logic signed [W-1:0]  den_d, den_q;
  logic signed [W-1:0]  exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
  logic signed [CompBits-1:0] xs, ys, zs, ws;

  assign xs = x_i;
  assign ys = y_i;
  assign zs = z_i;
  assign ws = w_i;

  // Stage one: all ten component products.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xx_q <= xs * xs;
      yy_q <= ys * ys;
      zz_q <= zs * zs;
      ww_q <= ws * ws;
      xy_q <= xs * ys;
      xz_q <= xs * zs;
      yz_q <= ys * zs;
      wx_q <= ws * xs;
      wy_q <= ws * ys;
      wz_q <= ws * zs;
    end
  end

  assign exx = W'(xx_q);
  assign eyy = W'(yy_q);
  assign ezz = W'(zz_q);
  assign eww = W'(ww_q);
  assign exy = W'(xy_q);
  assign exz = W'(xz_q);
  assign eyz = W'(yz_q);
  assign ewx = W'(wx_q);
  assign ewy = W'(wy_q);
  assign ewz = W'(wz_q);

  // Stage two: numerators over the common divisor n.
  always_comb begin
    den_d    = exx + eyy + ezz + eww;
    num_d[0] = exx + eww - eyy - ezz;
    num_d[1] = (exy - ewz) <<< 1;
    num_d[2] = (exz + ewy) <<< 1;
    num_d[3] = (exy + ewz) <<< 1;
    num_d[4] = eyy + eww - exx - ezz;
    num_d[5] = (eyz - ewx) <<< 1;
    num_d[6] = (exz - ewy) <<< 1;
    num_d[7] = (eyz + ewx) <<< 1;
    num_d[8] = ezz + eww - exx - eyy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      den_q <= den_d;
      num_q <= num_d;
    end
  end

  // Stage three: split into sign and magnitude, flag a zero norm.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      den_o  <= den_q;
      zero_o <= (den_q == '0);
      for (int i = 0; i < qrm_pkg::Lanes; i++) begin
        neg_o[i] <= num_q[i][W-1];
        mag_o[i] <= num_q[i][W-1] ? W'(-num_q[i]) : num_q[i];
      end
    end
  end

endmodule

// ===== sv/qrm_div.sv =====
// ----------------------------------------------------------------------------
// qrm_div: pipelined restoring divider
// One quotient bit per stage; the numerator never exceeds the divisor.
// ----------------------------------------------------------------------------
module qrm_div #(
  parameter int W = 34
) (
  input  logic                        clk_i,
  input  logic [qrm_pkg::QuoW-1:0]    en_i,
  input  logic [W-1:0]                num_i,
  input  logic [W-1:0]                den_i,
  input  logic [qrm_pkg::TagW-1:0]    tag_i,
  output logic [qrm_pkg::QuoW-1:0]    quo_o,
  output logic [qrm_pkg::TagW-1:0]    tag_o
);

  localparam int QB = qrm_pkg::QuoW;

  logic [W:0]              rem_q [QB];
  logic [W-1:0]            den_q [QB];
  logic [QB-1:0]           quo_q [QB];
  logic [qrm_pkg::TagW-1:0] tag_q [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [W:0]               rem_in;
    logic [W-1:0]             den_in;
    logic [QB-1:0]            quo_in;
    logic [qrm_pkg::TagW-1:0] tag_in;
    logic                     ge;

    // First stage takes the integer bit, later stages shift the remainder.
    if (i == 0) begin : g_first
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = {rem_q[i-1][W-1:0], 1'b0};
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    assign ge = (rem_in >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        rem_q[i] <= ge ? (rem_in - {1'b0, den_in}) : rem_in;
        den_q[i] <= den_in;
        quo_q[i] <= {quo_in[QB-2:0], ge};
        tag_q[i] <= tag_in;
      end
    end
  end

  assign quo_o = quo_q[QB-1];
  assign tag_o = tag_q[QB-1];

endmodule

// ===== sv/quaternion_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix: 3x3 rotation matrix from a quaternion
// Builds the nine Q2.16 entries of the matrix of a possibly unnormalized
// quaternion, each an exact ratio over the squared norm, rounded to nearest.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one quaternion per transfer in s_axis_tdata
//   (x, y, z, w from the lowest bits). The master stream gives one matrix per
//   transfer in m_axis_tdata (r00 ... r22 from the lowest bits, 18 bits
//   each) and the zero-quaternion flag in m_axis_tuser. A zero quaternion
//   returns the identity matrix with the flag set.
//   An input transfer passes three front stages (products, sums, magnitude),
//   one stage per quotient bit of the eighteen-bit restoring dividers and
//   the output register on its way to output valid. Throughput is one
//   quaternion per cycle while the receiver takes results.
//   Each stage holds its item while the one after it is full and stalled;
//   empty stages still fill, so input is taken until the pipeline is full.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
  parameter int COMP_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w from the lowest bit, zero padded
  input  logic [((4*COMP_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from the lowest bit, zero padded
  output logic [((qrm_pkg::Lanes*qrm_pkg::OutW+7)/8)*8-1:0] m_axis_tdata,
  // zero_quat
  output logic        m_axis_tuser
);

  localparam int W     = 2 * COMP_BITS + 2;
  localparam int QB    = qrm_pkg::QuoW;
  localparam int OW    = qrm_pkg::OutW;
  localparam int NF    = qrm_pkg::FrontStages;
  localparam int NS    = NF + QB + 1;
  localparam int OUTDW = ((qrm_pkg::Lanes * OW + 7) / 8) * 8;

  logic [NS-1:0] vld_q;
  logic [NS:0]   en;

  logic [W-1:0]  den;
  logic [W-1:0]  mag [qrm_pkg::Lanes];
  logic [qrm_pkg::Lanes-1:0] neg;
  logic          zero;

  logic [QB-1:0]             quo [qrm_pkg::Lanes];
  logic [qrm_pkg::TagW-1:0]  tag [qrm_pkg::Lanes];

  logic [OUTDW-1:0] tdata_d, tdata_q;
  logic             zero_d, zero_q;

  // Stage enables: a stage moves when it is empty or the next one moves.
  assign en[NS] = m_axis_tready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k+1];
  end

  assign s_axis_tready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Front end: products, numerators, magnitudes.
  qrm_front #(
    .CompBits(COMP_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .en_i   (en[NF-1:0]),
    .x_i    (s_axis_tdata[COMP_BITS-1:0]),
    .y_i    (s_axis_tdata[2*COMP_BITS-1:COMP_BITS]),
    .z_i    (s_axis_tdata[3*COMP_BITS-1:2*COMP_BITS]),
    .w_i    (s_axis_tdata[4*COMP_BITS-1:3*COMP_BITS]),
    .den_o  (den),
    .mag_o  (mag),
    .neg_o  (neg),
    .zero_o (zero)
  );

  // One divider lane per matrix entry.
  for (genvar l = 0; l < qrm_pkg::Lanes; l++) begin : g_lane
    logic [qrm_pkg::TagW-1:0] tag_in;
    assign tag_in[qrm_pkg::TagNeg]  = neg[l];
    assign tag_in[qrm_pkg::TagZero] = zero;

    qrm_div #(
      .W(W)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en[NF+QB-1:NF]),
      .num_i (mag[l]),
      .den_i (den),
      .tag_i (tag_in),
      .quo_o (quo[l]),
      .tag_o (tag[l])
    );
  end

  // Output stage: round half up on the magnitude, restore sign, identity on zero.
  always_comb begin
    logic [QB:0]   sum;
    logic [OW-1:0] mag_r;
    logic [OW-1:0] val;
    tdata_d = '0;
    zero_d  = tag[0][qrm_pkg::TagZero];
    for (int l = 0; l < qrm_pkg::Lanes; l++) begin
      sum   = {1'b0, quo[l]} + (QB+1)'(1);
      mag_r = OW'(sum[QB:1]);
      val   = tag[l][qrm_pkg::TagNeg] ? OW'(-mag_r) : mag_r;
      if (zero_d) begin
        val = (l % 4 == 0) ? OW'(1 << qrm_pkg::FracW) : '0;
      end
      tdata_d[l*OW +: OW] = val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      tdata_q <= tdata_d;
      zero_q  <= zero_d;
    end
  end

  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = zero_q;

endmodule

// ===== test/quaternion_to_rotation_matrix_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb: stream test of the quaternion to matrix block
// Feeds quaternions through the slave stream under several idle and stall
// patterns. A local predictor forms each exact ratio over the squared norm,
// rounds it and saturates it, and every output transfer is checked in order.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_tb;

  localparam int CompW    = 16;
  localparam int InW      = ((4 * CompW + 7) / 8) * 8;
  localparam int OutDataW = ((qrm_pkg::Lanes * qrm_pkg::OutW + 7) / 8) * 8;
  localparam int Latency  = 22;
  localparam int RandItems = 500;
  localparam int CycleLimit = 400000;
  localparam logic [17:0] One = 18'sd65536;

  typedef enum int {
    PhaseFree, PhaseSendIdle, PhaseRecvStall, PhaseBoth
  } phase_e;

  typedef struct packed {
    logic [OutDataW-1:0] entries;
    logic                zero_quat;
  } matrix_t;

  typedef struct {
    logic signed [15:0] x, y, z, w;
    logic               known;
    matrix_t            mat;
  } quat_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  matrix_t pending_matrices[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  phase_e  phase = PhaseFree;

  quaternion_to_rotation_matrix #(.COMP_BITS(CompW)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Rounded (ties away from zero), saturated Q2.16 value of num / den.
  function automatic logic [17:0] ratio_q16(logic signed [127:0] num,
                                            logic signed [127:0] den);
    logic [127:0]       mag;
    logic [127:0]       q;
    logic signed [63:0] v;
    mag = (num < 0) ? -num : num;
    q = ((mag << 17) / den + 1) >> 1;
    if (q > 131072) q = 131072;
    v = (num < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  // Expected matrix of one quaternion.
  function automatic matrix_t rotation_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                          logic signed [15:0] qz, logic signed [15:0] qw);
    logic signed [127:0] x, y, z, w, n;
    logic signed [127:0] num[9];
    matrix_t m;
    x = qx; y = qy; z = qz; w = qw;
    n = x*x + y*y + z*z + w*w;
    m.entries = '0;
    m.zero_quat = (n == 0);
    if (n == 0) begin
      m.entries[0*18 +: 18] = One;
      m.entries[4*18 +: 18] = One;
      m.entries[8*18 +: 18] = One;
      return m;
    end
    num[0] = x*x + w*w - y*y - z*z;
    num[1] = 2 * (x*y - w*z);
    num[2] = 2 * (x*z + w*y);
    num[3] = 2 * (x*y + w*z);
    num[4] = y*y + w*w - x*x - z*z;
    num[5] = 2 * (y*z - w*x);
    num[6] = 2 * (x*z - w*y);
    num[7] = 2 * (y*z + w*x);
    num[8] = z*z + w*w - x*x - y*y;
    for (int k = 0; k < 9; k++) m.entries[k*18 +: 18] = ratio_q16(num[k], n);
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // Hands one quaternion to the block, idling first as the phase asks.
  // The valid line stays high after a transfer so that items can follow
  // back to back; the caller drops it once the last item is taken.
  task automatic send_quat(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic signed [15:0] w,
                           matrix_t want);
    while ((phase == PhaseSendIdle || phase == PhaseBoth) &&
           $urandom_range(99) < ((phase == PhaseSendIdle) ? 72 : 9)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, z, y, x};
    pending_matrices.push_back(want);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return $signed(16'($urandom_range(7))) - 16'sd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver stalls per phase.
  always @(posedge clk_i) begin
    if (phase == PhaseRecvStall) m_axis_tready <= ($urandom_range(99) >= 72);
    else if (phase == PhaseBoth) m_axis_tready <= ($urandom_range(99) >= 9);
    else m_axis_tready <= 1'b1;
  end

  // Output checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_matrices.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tuser, 0);
      end else begin
        matrix_t want;
        want = pending_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (m_axis_tdata[k*18 +: 18] !== want.entries[k*18 +: 18])
            report_mismatch($sformatf("entry %0d", k), m_axis_tdata[k*18 +: 18],
                            want.entries[k*18 +: 18]);
        if (m_axis_tdata[OutDataW-1:162] !== '0)
          report_mismatch("padding", m_axis_tdata[OutDataW-1:162], 0);
        if (m_axis_tuser !== want.zero_quat)
          report_mismatch("zero_quat", m_axis_tuser, want.zero_quat);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    quat_row_t dir_rows[$];
    quat_row_t row;
    matrix_t   ident, want;
    int        drain;
    ident.entries = '0;
    ident.entries[0*18 +: 18] = One;
    ident.entries[4*18 +: 18] = One;
    ident.entries[8*18 +: 18] = One;
    ident.zero_quat = 1'b0;

    // Directed table: zero quaternion, identity, extremes and mixed signs.
    dir_rows.push_back('{0, 0, 0, 0, 1'b1, '{ident.entries, 1'b1}});
    dir_rows.push_back('{0, 0, 0, 16'sh7fff, 1'b1, ident});
    dir_rows.push_back('{0, 0, 0, 16'sh8000, 1'b1, ident});
    dir_rows.push_back('{0, 0, 0, 1, 1'b1, ident});
    dir_rows.push_back('{16'sh7fff, 0, 0, 0, 1'b0, ident});
    dir_rows.push_back('{0, 16'sh8000, 0, 0, 1'b0, ident});
    dir_rows.push_back('{0, 0, 16'sh7fff, 0, 1'b0, ident});
    dir_rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, ident});
    dir_rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, ident});
    dir_rows.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, ident});
    dir_rows.push_back('{1, -1, 1, -1, 1'b0, ident});
    dir_rows.push_back('{-1, 0, 0, 0, 1'b0, ident});
    dir_rows.push_back('{1, 1, 0, 0, 1'b0, ident});
    dir_rows.push_back('{0, 0, 1, 1, 1'b0, ident});
    dir_rows.push_back('{16'sh5555, 16'shaaaa, 16'sh1234, 16'shfedc, 1'b0, ident});
    dir_rows.push_back('{16'sh0001, 16'sh7fff, 0, 0, 1'b0, ident});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      want = row.known ? row.mat : rotation_of(row.x, row.y, row.z, row.w);
      send_quat(row.x, row.y, row.z, row.w, want);
    end
    s_axis_tvalid <= 1'b0;

    // Hold off until every expected matrix has arrived.
    while (pending_matrices.size() != 0) @(posedge clk_i);

    for (int i = 0; i < RandItems; i++) begin
      logic signed [15:0] x, y, z, w;
      phase = phase_e'((i / 50) % 4);
      x = rand_comp(); y = rand_comp(); z = rand_comp(); w = rand_comp();
      send_quat(x, y, z, w, rotation_of(x, y, z, w));
    end
    s_axis_tvalid <= 1'b0;
    phase = PhaseFree;

    while (pending_matrices.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 2 * Latency) begin
      @(posedge clk_i);
      drain++;
    end

    if (mismatch_count == 0 && pending_matrices.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== quaternion_to_rotation_matrix.f =====
sv/qrm_pkg.sv
sv/qrm_front.sv
sv/qrm_div.sv
sv/quaternion_to_rotation_matrix.sv
test/quaternion_to_rotation_matrix_tb.sv
